@@ hw/rtl/wqve_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wqve_pkg: shared types and constants
// Request/result payloads, the basis job passed from front to back, codes.
// ----------------------------------------------------------------------------
package wqve_pkg;

    // action codes
    localparam logic [1:0] ACT_DEPTH  = 2'd0;
    localparam logic [1:0] ACT_SELECT = 2'd1;
    localparam logic [1:0] ACT_HOVER  = 2'd2;
    localparam logic [1:0] ACT_MAIN   = 2'd3;

    localparam int C_STRIPS_PER_FACE = 4;
    localparam int C_QUEUE_DEPTH     = 2;

    // vertex counts minus one
    localparam logic [4:0] C_LAST_DEPTH = 5'd3;
    localparam logic [4:0] C_LAST_MAIN  = 5'd7;
    localparam logic [4:0] C_LAST_FRAME = 5'(2 * C_STRIPS_PER_FACE * 4 - 1);

    // offsets in Q.9
    localparam logic signed [10:0] C_HALF_UNIT = 11'sd256;
    localparam logic signed [10:0] C_ONE_UNIT  = 11'sd512;
    localparam logic signed [21:0] C_SEL_STRIP = 22'sd1024;
    localparam logic signed [21:0] C_HOV_STRIP = 22'sd512;

    localparam logic [15:0] C_TEX_HALF = 16'd16384;
    localparam logic [15:0] C_TEX_ONE  = 16'd32768;
    localparam logic signed [15:0] C_RIGHT_ONE = 16'sd16384;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] origin_z;
        logic signed [15:0] facing_x;
        logic signed [15:0] facing_y;
        logic signed [15:0] facing_z;
        logic [19:0]        span_width;
        logic [19:0]        span_height;
        logic [15:0]        uv_left;
        logic [15:0]        uv_right;
        logic               hover_active;
    } t_in_req;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [15:0]        tex_s;
        logic [15:0]        tex_t;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
        logic               poly_end;
        logic               last;
    } t_out_res;

    // request with its right vector resolved
    typedef struct packed {
        t_in_req            req;
        logic signed [15:0] rgt_x;
        logic signed [15:0] rgt_y;
    } t_job;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SQUARE,
        FS_CHECK,
        FS_ROOT,
        FS_DIVSET,
        FS_DIVIDE,
        FS_PUSH
    } t_front_state;

endpackage
`default_nettype wire

@@ hw/rtl/window_quad_vertex_expander.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// window_quad_vertex_expander: upright window to quad vertices
// Front solves the right vector, a job queue decouples it from the
// back end that emits one vertex per cycle while it holds a job.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The front squares
// the normal and tests the threshold; unless the normal is nearly vertical
// it then runs the square root, a divider setup step and the dividers. It
// then queues the job, waiting while the queue is full, so busy stays high
// after a request is taken until its job is queued; a hover request with
// hover inactive is dropped at intake and yields nothing. The back end emits
// one vertex per cycle while it holds a job (4, 8 or 32 per request), and
// moves on to the next queued job without a gap. Each vertex appears on
// o_res for one cycle with o_res_valid; the receiver cannot stall it.
// Sustained rate is set by the slower side: the front, whose time per request
// is longer when the normal is not nearly vertical, or the back, whose time
// per request depends on the action.
// ----------------------------------------------------------------------------
module window_quad_vertex_expander
    import wqve_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_in_req i_req,
    output logic         o_res_valid,
    output t_out_res     o_res
);

    logic q_push, q_full, q_pop, q_empty;
    t_job q_in, q_out;

    wqve_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in)
    );

    wqve_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out)
    );

    wqve_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_job     (q_out),
        .o_q_pop     (q_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

@@ hw/rtl/wqve_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wqve_front: request intake and right-vector solver
// Squares the normal, tests the fallback threshold; if above, runs an integer
// square root (two steps per cycle) and two restoring dividers. Queues a job.
// ----------------------------------------------------------------------------
module wqve_front
    import wqve_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_in_req i_req,
    input  wire logic    i_q_full,
    output logic         o_q_push,
    output t_job         o_q_job
);

    localparam logic [3:0] C_ROOT_LAST = 4'd14;

    typedef struct packed {
        logic [59:0] v;
        logic [59:0] res;
        logic [59:0] bits;
    } t_root;

    // one step of the bitwise integer square root
    function automatic t_root root_step(input t_root a);
        t_root r;
        logic [59:0] tr;
        r  = a;
        tr = a.res + a.bits;
        if (a.v >= tr) begin
            r.v   = a.v - tr;
            r.res = (a.res >> 1) + a.bits;
        end else begin
            r.res = a.res >> 1;
        end
        r.bits = a.bits >> 2;
        return r;
    endfunction

    t_front_state r_state, n_state;
    t_in_req      r_req;
    logic [31:0]  r_sumsq;
    logic         r_big;
    t_root        r_root;
    logic [3:0]   r_cnt;
    logic [29:0]  r_len;
    logic [45:0]  r_nx, r_ny, r_dv;
    logic [15:0]  r_qx, r_qy;
    logic [3:0]   r_dcnt;

    logic signed [31:0] w_sqx, w_sqy;
    logic [45:0]        w_thr;
    logic               w_big;
    logic               w_drop;
    t_root              w_root;
    logic [15:0]        w_magx, w_magy;

    assign w_sqx  = r_req.facing_x * r_req.facing_x;
    assign w_sqy  = r_req.facing_y * r_req.facing_y;
    assign w_thr  = 46'(r_sumsq) * 46'd10000;
    assign w_big  = w_thr > 46'(64'd1 << 28);
    assign w_drop = (i_req.action == ACT_HOVER) && !i_req.hover_active;
    assign w_root = root_step(root_step(r_root));
    assign w_magx = r_req.facing_x[15] ? 16'(-r_req.facing_x) : 16'(r_req.facing_x);
    assign w_magy = r_req.facing_y[15] ? 16'(-r_req.facing_y) : 16'(r_req.facing_y);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE:   if (start && !w_drop) n_state = FS_SQUARE;
            FS_SQUARE: n_state = FS_CHECK;
            FS_CHECK:  n_state = w_big ? FS_ROOT : FS_PUSH;
            FS_ROOT:   if (r_cnt == C_ROOT_LAST) n_state = FS_DIVSET;
            FS_DIVSET: n_state = FS_DIVIDE;
            FS_DIVIDE: if (r_dcnt == 4'd0) n_state = FS_PUSH;
            FS_PUSH:   if (!i_q_full) n_state = FS_IDLE;
            default:   n_state = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy          = (r_state != FS_IDLE);
        o_q_push      = (r_state == FS_PUSH) && !i_q_full;
        o_q_job.req   = r_req;
        o_q_job.rgt_x = C_RIGHT_ONE;
        o_q_job.rgt_y = '0;
        if (r_big) begin
            o_q_job.rgt_x = r_req.facing_y[15] ? signed'(r_qx) : -signed'(r_qx);
            o_q_job.rgt_y = r_req.facing_x[15] ? -signed'(r_qx ^ r_qx ^ r_qy)
                                               : signed'(r_qy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_IDLE: begin
                if (start) r_req <= i_req;
            end
            FS_SQUARE: begin
                r_sumsq <= $unsigned(w_sqx) + $unsigned(w_sqy);
            end
            FS_CHECK: begin
                r_big       <= w_big;
                r_root.v    <= {r_sumsq, 28'd0};
                r_root.res  <= '0;
                r_root.bits <= 60'd1 << 58;
                r_cnt       <= '0;
            end
            FS_ROOT: begin
                r_root <= w_root;
                r_cnt  <= r_cnt + 4'd1;
            end
            FS_DIVSET: begin
                r_len  <= r_root.res[29:0];
                r_nx   <= {2'd0, w_magx, 28'd0} + 46'(r_root.res[29:1]);
                r_ny   <= {2'd0, w_magy, 28'd0} + 46'(r_root.res[29:1]);
                r_dv   <= {1'b0, r_root.res[29:0], 15'd0};
                r_dcnt <= 4'd15;
            end
            FS_DIVIDE: begin
                // rx magnitude from fy, ry magnitude from fx
                if (r_ny >= r_dv) begin
                    r_ny <= r_ny - r_dv;
                    r_qx <= {r_qx[14:0], 1'b1};
                end else begin
                    r_qx <= {r_qx[14:0], 1'b0};
                end
                if (r_nx >= r_dv) begin
                    r_nx <= r_nx - r_dv;
                    r_qy <= {r_qy[14:0], 1'b1};
                end else begin
                    r_qy <= {r_qy[14:0], 1'b0};
                end
                r_dv   <= r_dv >> 1;
                r_dcnt <= r_dcnt - 4'd1;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_DIVIDE) |-> (r_len != '0))
        else $error("divider started with zero length");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/wqve_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wqve_queue: job queue between front and back
// Small register FIFO so intake and vertex emission stall independently.
// ----------------------------------------------------------------------------
module wqve_queue
    import wqve_pkg::*;
#(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            if (i_pop)  r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            if (i_push && !i_pop)      r_count <= r_count + CW'(1);
            else if (i_pop && !i_push) r_count <= r_count - CW'(1);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/wqve_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wqve_back: vertex emitter
// Walks the vertices of a job, one per cycle: offset select, multiply,
// then sum with round and saturate into the result register.
// ----------------------------------------------------------------------------
module wqve_back
    import wqve_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_job i_q_job,
    output logic      o_q_pop,
    output logic      o_res_valid,
    output t_out_res  o_res
);

    typedef struct packed {
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        poly_end;
        logic        last;
    } t_attr;

    typedef struct packed {
        logic signed [21:0] xo;
        logic signed [21:0] yo;
        logic signed [10:0] doff;
        t_job               job;
        t_attr              attr;
    } t_s1;

    typedef struct packed {
        logic signed [37:0] px;
        logic signed [37:0] py;
        logic signed [26:0] nx;
        logic signed [26:0] ny;
        logic signed [26:0] nz;
        logic signed [21:0] yo;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [23:0] oz;
        t_attr              attr;
    } t_s2;

    logic       r_active;
    logic [4:0] r_k, r_kmax;
    t_job       r_job;
    logic       r_s1_valid, r_s2_valid;
    t_s1        r_s1;
    t_s2        r_s2;
    logic       r_out_valid;
    t_out_res   r_out;

    logic               w_done;
    t_s1                w_s1;
    logic signed [21:0] w_hw, w_hh, w_bw, w_x0, w_y0, w_x1, w_y1, w_x, w_y;
    logic [1:0]         w_i, w_j;
    logic               w_face;
    logic signed [41:0] w_sx, w_sy, w_sz;

    // saturating round to Q.8
    function automatic logic signed [23:0] to_pos(input logic signed [41:0] acc);
        logic signed [26:0] p;
        p = 27'((acc + 42'sd16384) >>> 15);
        if (p > 27'sd8388607)       return 24'sh7FFFFF;
        else if (p < -27'sd8388608) return 24'sh800000;
        else                        return p[23:0];
    endfunction

    // job sequencing
    assign w_done  = !r_active || (r_k == r_kmax);
    assign o_q_pop = w_done && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_done) begin
            r_active <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
            r_k   <= '0;
            case (i_q_job.req.action)
                ACT_DEPTH: r_kmax <= C_LAST_DEPTH;
                ACT_MAIN:  r_kmax <= C_LAST_MAIN;
                default:   r_kmax <= C_LAST_FRAME;
            endcase
        end else if (r_active) begin
            r_k <= r_k + 5'd1;
        end
    end

    // offset select for vertex r_k
    assign w_i    = r_k[1:0];
    assign w_j    = r_k[3:2];
    assign w_face = r_k[4];
    assign w_hw   = 22'(signed'({1'b0, r_job.req.span_width}));
    assign w_hh   = 22'(signed'({1'b0, r_job.req.span_height}));
    assign w_bw   = (r_job.req.action == ACT_SELECT) ? C_SEL_STRIP : C_HOV_STRIP;

    always_comb begin
        case (w_j)
            2'd0: begin
                w_x0 = -w_hw;        w_y0 = -w_hh;
                w_x1 = -w_hw + w_bw; w_y1 = w_hh;
            end
            2'd1: begin
                w_x0 = w_hw - w_bw;  w_y0 = -w_hh;
                w_x1 = w_hw;         w_y1 = w_hh;
            end
            2'd2: begin
                w_x0 = -w_hw + w_bw; w_y0 = w_hh - w_bw;
                w_x1 = w_hw - w_bw;  w_y1 = w_hh;
            end
            default: begin
                w_x0 = -w_hw + w_bw; w_y0 = -w_hh;
                w_x1 = w_hw - w_bw;  w_y1 = -w_hh + w_bw;
            end
        endcase
        w_x = (w_i == 2'd0 || w_i == 2'd3) ? w_x0 : w_x1;
        w_y = (w_i[1] == 1'b0) ? w_y0 : w_y1;
    end

    always_comb begin
        w_s1.job           = r_job;
        w_s1.attr.poly_end = (w_i == 2'd3);
        w_s1.attr.last     = (r_k == r_kmax);
        w_s1.attr.tex_s    = C_TEX_HALF;
        w_s1.attr.tex_t    = C_TEX_HALF;
        w_s1.attr.red      = 8'd0;
        w_s1.attr.green    = 8'd0;
        w_s1.attr.blue     = 8'd0;
        w_s1.xo            = (w_i == 2'd0 || w_i == 2'd3) ? -w_hw : w_hw;
        w_s1.yo            = (w_i[1] == 1'b0) ? -w_hh : w_hh;
        w_s1.doff          = C_HALF_UNIT;
        unique case (r_job.req.action)
            ACT_DEPTH: ;
            ACT_SELECT, ACT_HOVER: begin
                w_s1.xo   = w_face ? -w_x : w_x;
                w_s1.yo   = w_y;
                w_s1.doff = w_face ? -C_HALF_UNIT : C_HALF_UNIT;
                w_s1.attr.red   = 8'd255;
                w_s1.attr.green = (r_job.req.action == ACT_SELECT) ? 8'd60 : 8'd0;
            end
            default: begin
                // main quad: back face mirrors x and depth
                if (r_k[2]) w_s1.xo = -w_s1.xo;
                w_s1.doff          = r_k[2] ? -C_ONE_UNIT : C_ONE_UNIT;
                w_s1.attr.tex_s    = (w_i == 2'd0 || w_i == 2'd3) ? r_job.req.uv_right
                                                                  : r_job.req.uv_left;
                w_s1.attr.tex_t    = (w_i[1] == 1'b0) ? C_TEX_ONE : 16'd0;
                w_s1.attr.red      = 8'd255;
                w_s1.attr.green    = 8'd255;
                w_s1.attr.blue     = 8'd255;
            end
        endcase
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= r_active;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // offset register and multiply stage
    always_ff @(posedge i_clk) begin
        r_s1    <= w_s1;
        r_s2.px <= r_s1.job.rgt_x * r_s1.xo;
        r_s2.py <= r_s1.job.rgt_y * r_s1.xo;
        r_s2.nx <= r_s1.job.req.facing_x * r_s1.doff;
        r_s2.ny <= r_s1.job.req.facing_y * r_s1.doff;
        r_s2.nz <= r_s1.job.req.facing_z * r_s1.doff;
        r_s2.yo <= r_s1.yo;
        r_s2.ox <= r_s1.job.req.origin_x;
        r_s2.oy <= r_s1.job.req.origin_y;
        r_s2.oz <= r_s1.job.req.origin_z;
        r_s2.attr <= r_s1.attr;
    end

    // sum, round, saturate
    assign w_sx = (42'(r_s2.ox) <<< 15) + 42'(r_s2.px) + 42'(r_s2.nx);
    assign w_sy = (42'(r_s2.oy) <<< 15) + 42'(r_s2.py) + 42'(r_s2.ny);
    assign w_sz = (42'(r_s2.oz) <<< 15) + (42'(r_s2.yo) <<< 14) + 42'(r_s2.nz);

    always_ff @(posedge i_clk) begin
        r_out.pos_x       <= to_pos(w_sx);
        r_out.pos_y       <= to_pos(w_sy);
        r_out.pos_z       <= to_pos(w_sz);
        r_out.tex_s       <= r_s2.attr.tex_s;
        r_out.tex_t       <= r_s2.attr.tex_t;
        r_out.color_red   <= r_s2.attr.red;
        r_out.color_green <= r_s2.attr.green;
        r_out.color_blue  <= r_s2.attr.blue;
        r_out.poly_end    <= r_s2.attr.poly_end;
        r_out.last        <= r_s2.attr.last;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef ASSERT_OFF
    a_k_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !w_done) |=> (r_k == $past(r_k) + 5'd1))
        else $error("vertex counter skipped");
    a_last_closes_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> r_out.poly_end)
        else $error("item ended inside a quad");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: window quad vertex expander testbench
// Drives window requests through the start/busy handshake, predicts every
// vertex with a local fixed-point model and checks each strobed result.
// ----------------------------------------------------------------------------
module tb_top;
    import wqve_pkg::*;

    localparam int N_RANDOM    = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_in_req  i_req;
    logic     o_res_valid;
    t_out_res o_res;

    t_out_res vert_q[$];
    int       n_err;
    int       n_cycle;
    int       idle_pct;

    window_quad_vertex_expander uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        n_cycle <= n_cycle + 1;
        if (n_cycle > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // position rounding: floor((v + 2^14) / 2^15), saturated to Q.8
    function automatic logic [23:0] round_pos(input longint acc);
        longint p;
        p = (acc + 16384) >>> 15;
        if (p > 8388607) p = 8388607;
        if (p < -8388608) p = -8388608;
        return p[23:0];
    endfunction

    function automatic longint isqrt(input longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint div_near(input longint num, input longint den);
        longint m, q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // expected vertices of one request
    task automatic push_vertices(input t_in_req r);
        longint org[3], nrm[3], rgt[3], upv[3];
        longint hw, hh, sumsq, len, xs[4], ys[4], x0, y0, x1, y1, bw, sg, acc;
        t_out_res v;
        int n, total, face, j, i, c;
        logic [7:0] cr, cg, cb;
        org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
        nrm[0] = r.facing_x; nrm[1] = r.facing_y; nrm[2] = r.facing_z;
        upv[0] = 0; upv[1] = 0; upv[2] = 16384;
        hw = r.span_width;
        hh = r.span_height;
        sumsq = nrm[0] * nrm[0] + nrm[1] * nrm[1];
        if (sumsq * 10000 > (64'sd1 << 28)) begin
            len = isqrt(sumsq << 28);
            rgt[0] = div_near(-nrm[1] * (64'sd1 << 28), len);
            rgt[1] = div_near(nrm[0] * (64'sd1 << 28), len);
        end else begin
            rgt[0] = 16384;
            rgt[1] = 0;
        end
        rgt[2] = 0;
        case (r.action)
            ACT_DEPTH:  total = 4;
            ACT_MAIN:   total = 8;
            ACT_SELECT: total = 32;
            default:    total = r.hover_active ? 32 : 0;
        endcase
        bw = (r.action == ACT_SELECT) ? 1024 : 512;
        cr = 255; cg = (r.action == ACT_SELECT) ? 8'd60 : 8'd0; cb = 0;
        for (n = 0; n < total; n++) begin
            i = n & 3;
            xs[0] = ((i == 0) || (i == 3)) ? -1 : 1;
            ys[0] = ((i == 0) || (i == 1)) ? -1 : 1;
            v = '0;
            if (r.action == ACT_DEPTH) begin
                x0 = xs[0] * hw; y0 = ys[0] * hh; sg = 256;
                v.tex_s = C_TEX_HALF; v.tex_t = C_TEX_HALF;
            end else if (r.action == ACT_MAIN) begin
                sg = (n < 4) ? 1 : -1;
                x0 = sg * xs[0] * hw; y0 = ys[0] * hh; sg = sg * 512;
                v.tex_s = (xs[0] < 0) ? r.uv_right : r.uv_left;
                v.tex_t = (ys[0] < 0) ? C_TEX_ONE : 16'd0;
                v.color_red = 255; v.color_green = 255; v.color_blue = 255;
            end else begin
                face = n / 16;
                j = (n / 4) % 4;
                case (j)
                    0: begin x1 = -hw; y1 = -hh; xs[1] = -hw + bw; ys[1] = hh; end
                    1: begin x1 = hw - bw; y1 = -hh; xs[1] = hw; ys[1] = hh; end
                    2: begin x1 = -hw + bw; y1 = hh - bw; xs[1] = hw - bw; ys[1] = hh; end
                    default: begin
                        x1 = -hw + bw; y1 = -hh; xs[1] = hw - bw; ys[1] = -hh + bw;
                    end
                endcase
                sg = face ? -1 : 1;
                x0 = ((i == 0) || (i == 3)) ? x1 : xs[1];
                y0 = ((i == 0) || (i == 1)) ? y1 : ys[1];
                x0 = sg * x0;
                sg = sg * 256;
                v.tex_s = C_TEX_HALF; v.tex_t = C_TEX_HALF;
                v.color_red = cr; v.color_green = cg; v.color_blue = cb;
            end
            for (c = 0; c < 3; c++) begin
                acc = org[c] * 32768 + rgt[c] * x0 + upv[c] * y0 + nrm[c] * sg;
                if (c == 0) v.pos_x = round_pos(acc);
                else if (c == 1) v.pos_y = round_pos(acc);
                else v.pos_z = round_pos(acc);
            end
            v.poly_end = (i == 3);
            v.last = (n == total - 1);
            vert_q.push_back(v);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (vert_q.size() == 0) begin
                n_err = n_err + 1;
                if (n_err <= 10) $display("unexpected vertex %h", o_res);
            end else begin
                if (o_res !== vert_q[0]) begin
                    n_err = n_err + 1;
                    if (n_err <= 10)
                        $display("vertex mismatch: exp %h got %h", vert_q[0], o_res);
                end
                void'(vert_q.pop_front());
            end
        end
    end

    // one request through the handshake, with random sender gaps;
    // start stays high after acceptance until the next gap or the end
    task automatic send_req(input t_in_req r);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        push_vertices(r);
    endtask

    function automatic logic [15:0] rnd_facing();
        case ($urandom_range(5))
            0: return 16'($urandom_range(32767) - 16384);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'($urandom_range(300) - 150);
            4: return 16'($urandom);
            default: return 16'($urandom_range(2000) - 1000);
        endcase
    endfunction

    function automatic t_in_req rnd_req();
        t_in_req r;
        r.action       = 2'($urandom);
        r.origin_x     = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20000));
        r.origin_y     = 24'($urandom);
        r.origin_z     = ($urandom_range(1)) ? 24'($urandom) : -24'sd5000;
        r.facing_x     = rnd_facing();
        r.facing_y     = rnd_facing();
        r.facing_z     = rnd_facing();
        r.span_width   = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(4000));
        r.span_height  = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(4000));
        r.uv_left      = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        r.uv_right     = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        r.hover_active = ($urandom_range(3) != 0);
        return r;
    endfunction

    // directed rows: action, origin, facing, size, uv, hover
    t_in_req dir_tab[12];
    t_out_res first_vert;

    initial begin
        n_err = 0; n_cycle = 0; idle_pct = 0;
        start = 1'b0; i_req = '0; i_rst_n = 1'b0;
        dir_tab[0]  = {ACT_DEPTH, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd16384, 16'sd0,
                       20'd512, 20'd256, 16'd0, 16'd32768, 1'b0};
        dir_tab[1]  = {ACT_MAIN, 24'sd100, -24'sd100, 24'sd7, 16'sd16384, 16'sd0, 16'sd0,
                       20'd1000, 20'd2000, 16'd32768, 16'd0, 1'b1};
        dir_tab[2]  = {ACT_SELECT, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd16384,
                       20'd300, 20'd300, 16'd1, 16'd2, 1'b0};
        dir_tab[3]  = {ACT_HOVER, 24'sd5, 24'sd5, 24'sd5, 16'sd11585, 16'sd11585, 16'sd0,
                       20'd100, 20'd100, 16'd0, 16'd0, 1'b1};
        dir_tab[4]  = {ACT_HOVER, 24'sd5, 24'sd5, 24'sd5, 16'sd11585, 16'sd11585, 16'sd0,
                       20'd100, 20'd100, 16'd0, 16'd0, 1'b0};
        dir_tab[5]  = {ACT_MAIN, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, -16'sd16384,
                       -16'sd16384, 16'sd16384, 20'hfffff, 20'hfffff, 16'hffff, 16'hffff, 1'b1};
        dir_tab[6]  = {ACT_SELECT, -24'sh800000, -24'sh800000, -24'sh800000, 16'sh7fff,
                       -16'sh8000, -16'sh8000, 20'hfffff, 20'hfffff, 16'd0, 16'd0, 1'b0};
        // threshold edge: sumsq*10000 just below and above 2^28
        dir_tab[7]  = {ACT_DEPTH, 24'sd0, 24'sd0, 24'sd0, 16'sd163, 16'sd0, 16'sd0,
                       20'd256, 20'd256, 16'd0, 16'd0, 1'b0};
        dir_tab[8]  = {ACT_DEPTH, 24'sd0, 24'sd0, 24'sd0, 16'sd164, 16'sd0, 16'sd0,
                       20'd256, 20'd256, 16'd0, 16'd0, 1'b0};
        // narrow window, strips overlap
        dir_tab[9]  = {ACT_SELECT, 24'sd0, 24'sd0, 24'sd0, 16'sd0, -16'sd16384, 16'sd0,
                       20'd10, 20'd0, 16'd0, 16'd0, 1'b1};
        dir_tab[10] = {ACT_HOVER, 24'sd0, 24'sd0, 24'sd0, -16'sd3, 16'sd2, -16'sd1,
                       20'd0, 20'd0, 16'd0, 16'd0, 1'b1};
        dir_tab[11] = {ACT_MAIN, -24'sd1, 24'sd1, -24'sd1, 16'sd100, -16'sd100, 16'sd0,
                       20'd1, 20'd1, 16'd32768, 16'd16384, 1'b0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part; first row also checked by hand: facing +Y gives right -X
        for (int k = 0; k < 12; k++) begin
            send_req(dir_tab[k]);
            if (k == 0) begin
                first_vert = vert_q[0];
                if (first_vert.pos_x !== 24'sd256 || first_vert.pos_y !== 24'sd128 ||
                    first_vert.pos_z !== -24'sd128 || first_vert.last !== 1'b0) begin
                    n_err = n_err + 1;
                    $display("depth corner mismatch: got %h", first_vert);
                end
            end
        end

        // random part in idling phases
        for (int k = 0; k < N_RANDOM; k++) begin
            case ((k * 4) / N_RANDOM)
                0: idle_pct = 0;
                1: idle_pct = 48;
                2: idle_pct = 0;
                default: idle_pct = 21;
            endcase
            send_req(rnd_req());
        end
        start <= 1'b0;

        while (vert_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
